// ===== sv/rccmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rccmf_pkg
// Shared types and constants for the ratio and cross-check match filter.
// ----------------------------------------------------------------------------
package rccmf_pkg;

    // Default table size and index width
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int INDEX_BITS_DEF  = 16;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int NCNT_W  = 2;
    localparam int DIST_W  = 32;
    localparam int RATIO_W = 17;
    localparam int FRAC_W  = 16;

    // Ratio limit after reset, about 0.65 in unsigned 1.16
    localparam logic [RATIO_W-1:0] RATIO_RESET = 17'd42598;

    // Command codes carried on tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // Control that travels with a search token along the cell row
    typedef struct packed {
        logic act;
        logic hit;
    } token_ctl_t;

endpackage

// ===== sv/ratio_and_cross_check_match_filter.sv =====
// ----------------------------------------------------------------------------
// ratio_and_cross_check_match_filter
// Ratio test and mutual cross-check of feature matches over a row of
// table cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_*; tuser carries the command (load reverse
//   entry, query forward entry, clear table), tdata the match fields.
//   One word is taken at a time: s_tready is high only while the block is
//   idle. Load, clear and the unused command pass through the check
//   state and return to idle. A query is ratio-tested; if it passes, a
//   search token walks the row of TABLE_DEPTH cells, one cell per cycle,
//   before the result word goes to the output register. A failed query
//   skips the row. The length of the cell row sets the query time.
//   A query yields one result word; loads and clears yield none.
//   Loads that pass the ratio test once the table is full are dropped and
//   set the sticky overflow flag, which a clear resets.
//   The result word sits in an output register; if the receiver stalls,
//   later loads and clears are still taken, and a further query waits at
//   its end until the output register is free.
//   Reset empties the table, clears the overflow flag and loads the ratio
//   limit with about 0.65. cfg_we writes the ratio limit; write only idle.
// ----------------------------------------------------------------------------
module ratio_and_cross_check_match_filter #(
    parameter int TABLE_DEPTH = rccmf_pkg::TABLE_DEPTH_DEF,
    parameter int INDEX_BITS  = rccmf_pkg::INDEX_BITS_DEF,
    parameter int IN_W  = ((rccmf_pkg::NCNT_W + 2 * INDEX_BITS
                            + 2 * rccmf_pkg::DIST_W + 7) / 8) * 8,
    parameter int OUT_W = ((3 + 2 * INDEX_BITS + rccmf_pkg::DIST_W + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // tdata: neighbour_count, query_index, train_index, best_distance,
    //        second_distance, zero fill
    input  logic [IN_W-1:0]                s_tdata,
    // tuser: cmd
    input  logic [rccmf_pkg::CMD_W-1:0]    s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: ratio_passed, mutual_found, match_query, match_train,
    //        match_distance, table_overflow, zero fill
    output logic [OUT_W-1:0]               m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_we,
    input  logic [rccmf_pkg::RATIO_W-1:0]  cfg_wdata
);
    import rccmf_pkg::*;

    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_DRAIN  = 4'b1000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;

    logic [RATIO_W-1:0]      ratio_limit_reg;
    logic [CMD_W-1:0]        cmd_reg;
    logic [NCNT_W-1:0]       ncnt_reg;
    logic [INDEX_BITS-1:0]   query_reg;
    logic [INDEX_BITS-1:0]   train_reg;
    logic [DIST_W-1:0]       best_reg;
    logic [DIST_W-1:0]       second_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic                    overflow_reg;
    logic                    pass_reg;
    logic                    found_reg;
    logic [OUT_W-1:0]        out_data_reg;
    logic                    out_valid_reg;

    logic                    in_fire;
    logic                    pass;
    logic                    table_full;
    logic                    load_en;
    logic                    out_free;
    logic                    out_load;

    logic [INDEX_BITS-1:0]   chain_kq  [TABLE_DEPTH+1];
    logic [INDEX_BITS-1:0]   chain_kt  [TABLE_DEPTH+1];
    token_ctl_t              chain_ctl [TABLE_DEPTH+1];

    // Handshake
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = (state_reg == ST_DRAIN) && out_free;

    // Ratio test on the held word
    rccmf_ratio_check u_ratio (
        .neighbour_count (ncnt_reg),
        .best_distance   (best_reg),
        .second_distance (second_reg),
        .ratio_limit     (ratio_limit_reg),
        .pass            (pass)
    );

    assign table_full = (count_reg == COUNT_W'(TABLE_DEPTH));
    assign load_en    = (state_reg == ST_CHECK) && (cmd_reg == CMD_LOAD) && pass && !table_full;

    // Token injection into the first cell: search for swapped indices
    assign chain_kq[0]  = train_reg;
    assign chain_kt[0]  = query_reg;
    assign chain_ctl[0] = '{act: (state_reg == ST_CHECK) && (cmd_reg == CMD_QUERY) && pass,
                            hit: 1'b0};

    // Row of table cells
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        rccmf_cell #(
            .INDEX_BITS (INDEX_BITS),
            .COUNT_W    (COUNT_W),
            .CELL_ID    (i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .count         (count_reg),
            .load_en       (load_en),
            .load_query    (query_reg),
            .load_train    (train_reg),
            .key_query_in  (chain_kq[i]),
            .key_train_in  (chain_kt[i]),
            .ctl_in        (chain_ctl[i]),
            .key_query_out (chain_kq[i+1]),
            .key_train_out (chain_kt[i+1]),
            .ctl_out       (chain_ctl[i+1])
        );
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (cmd_reg == CMD_QUERY)
                begin
                    state_next = pass ? ST_SEARCH : ST_DRAIN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                if (chain_ctl[TABLE_DEPTH].act)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Ratio limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_limit_reg <= RATIO_RESET;
        end
        else if (cfg_we)
        begin
            ratio_limit_reg <= cfg_wdata;
        end
    end

    // Held input word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg    <= s_tuser;
            ncnt_reg   <= s_tdata[NCNT_W-1:0];
            query_reg  <= s_tdata[NCNT_W +: INDEX_BITS];
            train_reg  <= s_tdata[NCNT_W + INDEX_BITS +: INDEX_BITS];
            best_reg   <= s_tdata[NCNT_W + 2 * INDEX_BITS +: DIST_W];
            second_reg <= s_tdata[NCNT_W + 2 * INDEX_BITS + DIST_W +: DIST_W];
        end
    end

    // Fill count and sticky overflow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (state_reg == ST_CHECK)
        begin
            case (cmd_reg)
                CMD_CLEAR:
                begin
                    count_reg    <= '0;
                    overflow_reg <= 1'b0;
                end
                CMD_LOAD:
                begin
                    if (load_en)
                    begin
                        count_reg <= count_reg + COUNT_W'(1);
                    end
                    else if (pass)
                    begin
                        overflow_reg <= 1'b1;
                    end
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    // Query outcome
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_CHECK) && (cmd_reg == CMD_QUERY))
        begin
            pass_reg  <= pass;
            found_reg <= 1'b0;
        end
        else if ((state_reg == ST_SEARCH) && chain_ctl[TABLE_DEPTH].act)
        begin
            found_reg <= chain_ctl[TABLE_DEPTH].hit;
        end
    end

    // Output register, zero fill above the last field
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= OUT_W'({overflow_reg, best_reg, train_reg, query_reg,
                                    found_reg, pass_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

endmodule

// ===== sv/rccmf_ratio_check.sv =====
// ----------------------------------------------------------------------------
// rccmf_ratio_check
// Ratio test by cross-multiplication: best * 2^16 <= limit * second, and at
// least two neighbours.
// ----------------------------------------------------------------------------
module rccmf_ratio_check (
    input  logic [rccmf_pkg::NCNT_W-1:0]  neighbour_count,
    input  logic [rccmf_pkg::DIST_W-1:0]  best_distance,
    input  logic [rccmf_pkg::DIST_W-1:0]  second_distance,
    input  logic [rccmf_pkg::RATIO_W-1:0] ratio_limit,
    output logic                          pass
);
    import rccmf_pkg::*;

    localparam int PROD_W = DIST_W + RATIO_W;

    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;

    // Scaled best distance against limit times second distance
    assign lhs  = PROD_W'({best_distance, {FRAC_W{1'b0}}});
    assign rhs  = PROD_W'(ratio_limit) * PROD_W'(second_distance);
    // A count of two or three means at least two neighbours
    assign pass = neighbour_count[1] && (lhs <= rhs);

endmodule

// ===== sv/rccmf_cell.sv =====
// ----------------------------------------------------------------------------
// rccmf_cell
// One table entry with its own comparator; passes the search token on to
// the next cell every cycle.
// ----------------------------------------------------------------------------
module rccmf_cell #(
    parameter int INDEX_BITS = rccmf_pkg::INDEX_BITS_DEF,
    parameter int COUNT_W    = 11,
    parameter int CELL_ID    = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [COUNT_W-1:0]      count,
    input  logic                    load_en,
    input  logic [INDEX_BITS-1:0]   load_query,
    input  logic [INDEX_BITS-1:0]   load_train,
    input  logic [INDEX_BITS-1:0]   key_query_in,
    input  logic [INDEX_BITS-1:0]   key_train_in,
    input  rccmf_pkg::token_ctl_t   ctl_in,
    output logic [INDEX_BITS-1:0]   key_query_out,
    output logic [INDEX_BITS-1:0]   key_train_out,
    output rccmf_pkg::token_ctl_t   ctl_out
);
    import rccmf_pkg::*;

    logic [INDEX_BITS-1:0] entry_query_reg;
    logic [INDEX_BITS-1:0] entry_train_reg;
    logic [INDEX_BITS-1:0] key_query_reg;
    logic [INDEX_BITS-1:0] key_train_reg;
    token_ctl_t            ctl_reg;
    token_ctl_t            ctl_next;
    logic                  in_use;
    logic                  match;

    // Entry is live when it lies below the fill count
    assign in_use = count > COUNT_W'(CELL_ID);
    assign match  = (entry_query_reg == key_query_in) && (entry_train_reg == key_train_in);

    always_comb
    begin
        ctl_next.act = ctl_in.act;
        ctl_next.hit = ctl_in.hit | (ctl_in.act & in_use & match);
    end

    // Entry write when this cell is the next free slot
    always_ff @(posedge clk)
    begin
        if (load_en && (count == COUNT_W'(CELL_ID)))
        begin
            entry_query_reg <= load_query;
            entry_train_reg <= load_train;
        end
    end

    // Key stage, no reset needed
    always_ff @(posedge clk)
    begin
        key_query_reg <= key_query_in;
        key_train_reg <= key_train_in;
    end

    // Token control stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    assign key_query_out = key_query_reg;
    assign key_train_out = key_train_reg;
    assign ctl_out       = ctl_reg;

endmodule

// ===== test/ratio_and_cross_check_match_filter_test.sv =====
// ----------------------------------------------------------------------------
// ratio_and_cross_check_match_filter_test
// Self-checking bench for the ratio and cross-check match filter. Load, query,
// clear and unused words are streamed in with random gaps. A local table model
// predicts every query result, which is compared with the output words in
// order. The bench runs through several ratio limits and fills the table
// past capacity once.
// ----------------------------------------------------------------------------
module ratio_and_cross_check_match_filter_test;

    import rccmf_pkg::*;

    localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
    localparam int INDEX_BITS  = INDEX_BITS_DEF;
    localparam int IN_W  = ((NCNT_W + 2 * INDEX_BITS + 2 * DIST_W + 7) / 8) * 8;
    localparam int OUT_W = ((3 + 2 * INDEX_BITS + DIST_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
    localparam int PHASE_WORDS = 12;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One input word before packing
    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [NCNT_W-1:0] ncnt;
        logic [15:0]       query;
        logic [15:0]       train;
        logic [31:0]       best;
        logic [31:0]       second;
    } match_in_t;

    // One result word, fields as on m_tdata, highest bits first
    typedef struct packed {
        logic        overflow;
        logic [31:0] distance;
        logic [15:0] train;
        logic [15:0] query;
        logic        mutual;
        logic        passed;
    } match_out_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic [IN_W-1:0]    s_tdata = '0;
    logic [CMD_W-1:0]   s_tuser = CMD_LOAD;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic               cfg_we = 1'b0;
    logic [RATIO_W-1:0] cfg_wdata = '0;

    // Stimulus and scoreboard state
    match_in_t    pending_words[$];
    match_out_t   expected_matches[$];
    logic [31:0]  recent_loads[$];
    int           words_queued = 0;
    int           words_taken = 0;
    int           errors = 0;
    int           cycle_count = 0;
    int           in_hold = 0;
    int           out_hold = 0;
    bit           in_taken = 1'b0;
    bit           idling_on = 1'b1;
    match_in_t    drv_word;
    match_out_t   got_match;
    match_out_t   want_match;

    // Table model
    logic [15:0]        table_query[TABLE_DEPTH];
    logic [15:0]        table_train[TABLE_DEPTH];
    int                 table_fill = 0;
    bit                 table_overflowed = 1'b0;
    logic [RATIO_W-1:0] ratio_setting = RATIO_RESET;

    ratio_and_cross_check_match_filter #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .INDEX_BITS  (INDEX_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Apply one accepted word to the table model; returns 1 with the
    // expected result when the word is a query
    function automatic bit filter_word(input logic [CMD_W-1:0] c,
                                       input logic [IN_W-1:0] d,
                                       output match_out_t res);
        logic [1:0]  nc;
        logic [15:0] q;
        logic [15:0] t;
        logic [31:0] b;
        logic [31:0] s;
        bit          pass;
        bit          hit;
        nc = d[1:0];
        q  = d[17:2];
        t  = d[33:18];
        b  = d[65:34];
        s  = d[97:66];
        res = '0;
        filter_word = 1'b0;
        // cross-multiplied ratio test, limit in 1.16, 16 fraction bits on both sides
        pass = (nc >= 2) && ({16'b0, b, 16'b0} <= 64'(ratio_setting) * 64'(s));
        case (c)
            CMD_CLEAR:
            begin
                table_fill = 0;
                table_overflowed = 1'b0;
            end
            CMD_LOAD:
            begin
                if (pass)
                begin
                    if (table_fill < TABLE_DEPTH)
                    begin
                        table_query[table_fill] = q;
                        table_train[table_fill] = t;
                        table_fill++;
                    end
                    else
                        table_overflowed = 1'b1;
                end
            end
            CMD_QUERY:
            begin
                // mutual entry has the indices swapped
                hit = 1'b0;
                for (int i = 0; i < table_fill; i++)
                    if (table_query[i] == t && table_train[i] == q)
                        hit = 1'b1;
                res = '{passed: pass, mutual: pass && hit, query: q, train: t,
                        distance: b, overflow: table_overflowed};
                filter_word = 1'b1;
            end
            default: ;
        endcase
    endfunction

    task automatic queue_word(input logic [CMD_W-1:0] c, input logic [1:0] nc,
                              input logic [15:0] q, input logic [15:0] t,
                              input logic [31:0] b, input logic [31:0] s);
        match_in_t w;
        w = '{c, nc, q, t, b, s};
        pending_words.insert(pending_words.size(), w);
        words_queued++;
    endtask

    // Indices: mostly a small pool so that mutual pairs meet
    function automatic logic [15:0] pick_index();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: pick_index = 16'($urandom_range(0, 15));
            6:                pick_index = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default:          pick_index = 16'($urandom);
        endcase
    endfunction

    // Distances: zero and full-scale seconds, the pass/fail knee, sure passes, random pairs
    task automatic pick_distances(output logic [31:0] b, output logic [31:0] s);
        longint knee;
        s = $urandom >> $urandom_range(0, 31);
        knee = longint'((64'(ratio_setting) * 64'(s)) >> 16);
        case ($urandom_range(0, 9))
            0:
            begin
                s = '0;
                b = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(1, 3));
            end
            1:
            begin
                s = 32'hFFFF_FFFF;
                b = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
            end
            2, 3, 4, 5:
            begin
                knee = knee + (int'($urandom_range(0, 4)) - 2);
                if (knee < 0)
                    knee = 0;
                if (knee > 64'hFFFF_FFFF)
                    knee = 64'hFFFF_FFFF;
                b = 32'(knee);
            end
            6, 7:
                b = 32'(knee / $urandom_range(1, 4));
            default:
            begin
                b = $urandom;
                s = $urandom;
            end
        endcase
    endtask

    // Random mix: loads and queries dominate, many queries swap the indices of a recent load
    task automatic queue_random(input int n);
        logic [CMD_W-1:0] c;
        logic [1:0]       nc;
        logic [15:0]      q;
        logic [15:0]      t;
        logic [31:0]      b;
        logic [31:0]      s;
        logic [31:0]      pair;
        int               r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            c = (r < 50) ? CMD_LOAD : (r < 88) ? CMD_QUERY : (r < 92) ? CMD_CLEAR
                                                                   : CMD_UNUSED;
            q = pick_index();
            t = pick_index();
            if (c == CMD_QUERY && recent_loads.size() != 0 && $urandom_range(0, 1))
            begin
                pair = recent_loads[$urandom_range(0, recent_loads.size() - 1)];
                q = pair[31:16];
                t = pair[15:0];
            end
            if (c == CMD_LOAD)
            begin
                recent_loads.insert(recent_loads.size(), {t, q});
                if (recent_loads.size() > 32)
                    void'(recent_loads.pop_front());
            end
            case ($urandom_range(0, 9))
                0:       nc = 2'd0;
                1:       nc = 2'd1;
                2, 3:    nc = 2'd3;
                default: nc = 2'd2;
            endcase
            pick_distances(b, s);
            queue_word(c, nc, q, t, b, s);
        end
    endtask

    // Wait for all words taken and all results back, then let the block go quiet
    task automatic settle();
        while (words_taken != words_queued || expected_matches.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_ratio(input logic [RATIO_W-1:0] v);
        @(negedge clk);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        ratio_setting = v;
    endtask

    // Input driver: next word or an idle burst once the current word is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (in_hold > 0)
                begin
                    in_hold--;
                    s_tvalid <= 1'b0;
                end
                else if (idling_on && $urandom_range(0, 4) == 0)
                begin
                    in_hold = $urandom_range(0, 6);
                    s_tvalid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    drv_word = pending_words.pop_front();
                    s_tuser  <= drv_word.cmd;
                    s_tdata  <= {6'b0, drv_word.second, drv_word.best,
                                 drv_word.train, drv_word.query, drv_word.ncnt};
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Output receiver: random stall bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_hold > 0)
            begin
                out_hold--;
                m_tready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                out_hold = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: check result words, feed accepted input words to the model
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got_match = m_tdata[66:0];
                if (expected_matches.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result word %h", m_tdata);
                end
                else
                begin
                    want_match = expected_matches.pop_front();
                    if (got_match.passed   !== want_match.passed   ||
                        got_match.mutual   !== want_match.mutual   ||
                        got_match.query    !== want_match.query    ||
                        got_match.train    !== want_match.train    ||
                        got_match.distance !== want_match.distance ||
                        got_match.overflow !== want_match.overflow)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected pass=%0d mutual=%0d q=%h t=%h ",
                                      "dist=%h ovf=%0d, got pass=%0d mutual=%0d q=%h ",
                                      "t=%h dist=%h ovf=%0d"},
                                     want_match.passed, want_match.mutual,
                                     want_match.query, want_match.train,
                                     want_match.distance, want_match.overflow,
                                     got_match.passed, got_match.mutual,
                                     got_match.query, got_match.train,
                                     got_match.distance, got_match.overflow);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                words_taken++;
                if (filter_word(s_tuser, s_tdata, want_match))
                    expected_matches.insert(expected_matches.size(), want_match);
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset ratio limit
        queue_word(CMD_QUERY, 2'd2, 16'h0003, 16'h0004, 32'd0, 32'd0);  // zero second passes
        queue_word(CMD_QUERY, 2'd2, 16'h0003, 16'h0004, 32'd1, 32'd0);  // zero second fails
        queue_word(CMD_QUERY, 2'd0, 16'h0003, 16'h0004, 32'd0, 32'd9);
        queue_word(CMD_QUERY, 2'd1, 16'h0003, 16'h0004, 32'd0, 32'd9);
        queue_word(CMD_QUERY, 2'd3, 16'h0003, 16'h0004, 32'd1, 32'd9);  // count of three
        queue_word(CMD_LOAD,  2'd2, 16'h0005, 16'h0009, 32'd1, 32'd8);
        queue_word(CMD_QUERY, 2'd2, 16'h0009, 16'h0005, 32'd2, 32'd8);  // mutual hit
        queue_word(CMD_QUERY, 2'd2, 16'h0009, 16'h0005, 32'd8, 32'd8);  // failed query echo
        queue_word(CMD_LOAD,  2'd2, 16'h0007, 16'h0008, 32'd9, 32'd9);  // failed load
        queue_word(CMD_QUERY, 2'd2, 16'h0008, 16'h0007, 32'd0, 32'd9);
        queue_word(CMD_LOAD,  2'd3, 16'h0005, 16'h0009, 32'd0, 32'd1);  // duplicate
        queue_word(CMD_QUERY, 2'd2, 16'h0009, 16'h0005, 32'd0, 32'd1);
        queue_word(CMD_UNUSED, 2'd2, 16'h0001, 16'h0002, 32'd0, 32'd1);
        queue_word(CMD_QUERY, 2'd2, 16'h0002, 16'h0001, 32'd0, 32'd1);
        queue_word(CMD_LOAD,  2'd2, 16'hFFFF, 16'h0000, 32'd0, 32'hFFFF_FFFF);
        queue_word(CMD_QUERY, 2'd2, 16'h0000, 16'hFFFF, 32'd0, 32'hFFFF_FFFF);
        queue_word(CMD_QUERY, 2'd2, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_word(CMD_QUERY, 2'd2, 16'h0010, 16'h0011, 32'd42598, 32'h0001_0000);
        queue_word(CMD_QUERY, 2'd2, 16'h0010, 16'h0011, 32'd42599, 32'h0001_0000);
        queue_word(CMD_CLEAR, 2'd0, 16'h0000, 16'h0000, 32'd0, 32'd0);
        queue_word(CMD_QUERY, 2'd2, 16'h0009, 16'h0005, 32'd0, 32'd1);  // gone after clear
        settle();

        // Random phases over a spread of limits
        write_ratio('0);
        queue_random(PHASE_WORDS);
        settle();
        write_ratio(17'd65536);
        queue_random(PHASE_WORDS);
        settle();
        write_ratio(17'd1);
        queue_random(PHASE_WORDS);
        settle();
        write_ratio(RATIO_W'($urandom_range(0, 65536)));
        queue_random(PHASE_WORDS);
        settle();

        // Fill the table exactly, then overrun it
        write_ratio(17'd32768);
        queue_word(CMD_CLEAR, 2'd0, 16'h0000, 16'h0000, 32'd0, 32'd0);
        queue_word(CMD_LOAD, 2'd2, 16'h1111, 16'h2222, 32'd0, $urandom);
        for (int i = 1; i < TABLE_DEPTH; i++)
            queue_word(CMD_LOAD, 2'd2, pick_index(), pick_index(), 32'd0, $urandom);
        queue_word(CMD_QUERY, 2'd2, 16'h2222, 16'h1111, 32'd0, 32'd0);
        queue_word(CMD_LOAD,  2'd2, 16'hABCD, 16'h1234, 32'd0, 32'd1);  // dropped
        queue_word(CMD_LOAD,  2'd0, 16'hABCD, 16'h1234, 32'd0, 32'd1);
        queue_word(CMD_QUERY, 2'd2, 16'h1234, 16'hABCD, 32'd0, 32'd5);
        queue_word(CMD_UNUSED, 2'd2, 16'h0000, 16'h0000, 32'd0, 32'd0);
        queue_word(CMD_QUERY, 2'd3, 16'h2222, 16'h1111, 32'd1, 32'd7);
        queue_word(CMD_CLEAR, 2'd0, 16'h0000, 16'h0000, 32'd0, 32'd0);
        queue_word(CMD_QUERY, 2'd2, 16'h2222, 16'h1111, 32'd0, 32'd0);
        settle();

        write_ratio(RATIO_RESET);
        queue_random(PHASE_WORDS);
        settle();

        // Last phase without gaps or stalls
        idling_on = 1'b0;
        write_ratio(RATIO_W'($urandom_range(0, 65536)));
        queue_random(PHASE_WORDS);
        settle();

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== ratio_and_cross_check_match_filter.f =====
sv/rccmf_pkg.sv
sv/rccmf_ratio_check.sv
sv/rccmf_cell.sv
sv/ratio_and_cross_check_match_filter.sv
test/ratio_and_cross_check_match_filter_test.sv
